### hdl/swarq_pkg.sv
// Shared types and constants for the sliding window ARQ sender.
`timescale 1ns / 1ps
`default_nettype none
package swarq_pkg;

  localparam int MAX_PACKETS = 1024;
  localparam int MAX_WINDOW  = 32;
  localparam int PKT_W       = $clog2(MAX_PACKETS);
  localparam int SEQ_W       = $clog2(MAX_PACKETS + 1);
  localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
  localparam int RETRY_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int QUEUE_DEPTH = 2;

  // Event kinds as carried on the input word.
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Error codes reported in every result word.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FAILED = 2'd1;
  localparam logic [1:0] ERR_RANGE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PKT_W-1:0] ack_seq;
  } in_word_t;

  typedef struct packed {
    logic             send_valid;
    logic [PKT_W-1:0] send_seq;
    logic             is_retransmit;
    logic [SEQ_W-1:0] window_base;
    logic             done_res;
    logic [1:0]       error_code;
    logic             last;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_ACK,
    OP_TIMEOUT,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [PKT_W-1:0] ack_seq;
  } cmd_t;

  // Clamped configuration as seen by the sequencer.
  typedef struct packed {
    logic [WIN_W-1:0]   window;
    logic [SEQ_W-1:0]   total;
    logic [RETRY_W-1:0] retry_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_RD,
    ST_TO_RD,
    ST_SLIDE,
    ST_SLIDE_CHK,
    ST_SEND
  } back_state_e;

endpackage
`default_nettype wire

### hdl/swarq_front.sv
// Input side: decode event words into commands and hold them in a short queue.
`timescale 1ns / 1ps
`default_nettype none
module swarq_front import swarq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_data_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_pop_i
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;
  cmd_t             cmd_new;

  always_comb begin
    cmd_new.ack_seq = in_data_i.ack_seq;
    case (in_data_i.kind)
      KIND_START:   cmd_new.op = OP_START;
      KIND_ACK:     cmd_new.op = OP_ACK;
      KIND_TIMEOUT: cmd_new.op = OP_TIMEOUT;
      default:      cmd_new.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (count_q != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

### hdl/swarq_back.sv
// Execution side: window state, ack and retry memories, result output register.
`timescale 1ns / 1ps
`default_nettype none
module swarq_back import swarq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  cmd_valid_i,
  input  wire cmd_t  cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_word_t  out_data_o
);

  back_state_e      state_q, state_d;
  logic [SEQ_W-1:0] base_q, base_d;
  logic [SEQ_W-1:0] next_q, next_d;
  logic [WIN_W-1:0] credit_q, credit_d;
  logic [WIN_W-1:0] slid_q, slid_d;
  logic             failed_q, failed_d;
  logic [PKT_W-1:0] aseq_q, aseq_d;
  logic             ov_q, ov_d;
  out_word_t        od_q, od_d;

  logic               mark_mem [MAX_PACKETS];
  logic [RETRY_W-1:0] ret_mem  [MAX_PACKETS];
  logic               mark_we, mark_wd, mark_re, mark_rd_q;
  logic [PKT_W-1:0]   mark_wa, mark_ra;
  logic               ret_we, ret_re;
  logic [PKT_W-1:0]   ret_wa, ret_ra;
  logic [RETRY_W-1:0] ret_wd, ret_rd_q;

  logic      can_emit, emit, base_done, last_send;
  out_word_t emit_word;
  logic [1:0] status_err;

  function automatic out_word_t mk_word(logic valid, logic [PKT_W-1:0] seq, logic retx,
                                        logic [SEQ_W-1:0] base, logic done,
                                        logic [1:0] err, logic last);
    out_word_t w;
    w.send_valid    = valid;
    w.send_seq      = seq;
    w.is_retransmit = retx;
    w.window_base   = base;
    w.done_res      = done;
    w.error_code    = err;
    w.last          = last;
    return w;
  endfunction

  assign can_emit   = !ov_q || out_ready_i;
  assign base_done  = (base_q >= cfg_i.total);
  assign status_err = failed_q ? ERR_FAILED : ERR_NONE;
  assign last_send  = (credit_q == WIN_W'(1)) ||
                      ((SEQ_W + 1)'(next_q) + 1'b1 >= (SEQ_W + 1)'(cfg_i.total));

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    next_d    = next_q;
    credit_d  = credit_q;
    slid_d    = slid_q;
    failed_d  = failed_q;
    aseq_d    = aseq_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    emit_word = mk_word(1'b0, '0, 1'b0, base_q, base_done, status_err, 1'b1);
    mark_we   = 1'b0;
    mark_wa   = next_q[PKT_W-1:0];
    mark_wd   = 1'b0;
    mark_re   = 1'b0;
    mark_ra   = base_q[PKT_W-1:0];
    ret_we    = 1'b0;
    ret_wa    = next_q[PKT_W-1:0];
    ret_wd    = '0;
    ret_re    = 1'b0;
    ret_ra    = base_q[PKT_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_START: begin
              cmd_pop_o = 1'b1;
              base_d    = '0;
              next_d    = '0;
              credit_d  = cfg_i.window;
              failed_d  = 1'b0;
              state_d   = ST_SEND;
            end
            OP_ACK: begin
              if (failed_q || base_done) begin
                if (can_emit) begin
                  cmd_pop_o = 1'b1;
                  emit      = 1'b1;
                end
              end else if (SEQ_W'(cmd_i.ack_seq) >= next_q) begin
                if (can_emit) begin
                  cmd_pop_o            = 1'b1;
                  emit                 = 1'b1;
                  emit_word.error_code = ERR_RANGE;
                end
              end else begin
                cmd_pop_o = 1'b1;
                mark_re   = 1'b1;
                mark_ra   = cmd_i.ack_seq;
                aseq_d    = cmd_i.ack_seq;
                state_d   = ST_ACK_RD;
              end
            end
            OP_TIMEOUT: begin
              if (!failed_q && !base_done && (base_q < next_q)) begin
                cmd_pop_o = 1'b1;
                ret_re    = 1'b1;
                state_d   = ST_TO_RD;
              end else if (can_emit) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
              end
            end
            default: begin
              if (can_emit) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
              end
            end
          endcase
        end
      end

      ST_ACK_RD: begin
        if (mark_rd_q) begin
          // duplicate ack: report and change nothing
          if (can_emit) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (SEQ_W'(aseq_q) == base_q) begin
          mark_we = 1'b1;
          mark_wa = aseq_q;
          mark_wd = 1'b1;
          base_d  = base_q + 1'b1;
          slid_d  = WIN_W'(1);
          state_d = ST_SLIDE;
        end else if (can_emit) begin
          mark_we = 1'b1;
          mark_wa = aseq_q;
          mark_wd = 1'b1;
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_SLIDE: begin
        if (base_q < next_q) begin
          mark_re = 1'b1;
          state_d = ST_SLIDE_CHK;
        end else begin
          credit_d = slid_q;
          state_d  = ST_SEND;
        end
      end

      ST_SLIDE_CHK: begin
        if (mark_rd_q) begin
          base_d  = base_q + 1'b1;
          slid_d  = (slid_q == WIN_W'(MAX_WINDOW)) ? slid_q : slid_q + 1'b1;
          state_d = ST_SLIDE;
        end else begin
          credit_d = slid_q;
          state_d  = ST_SEND;
        end
      end

      ST_SEND: begin
        if ((credit_q != '0) && (next_q < cfg_i.total)) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_word = mk_word(1'b1, next_q[PKT_W-1:0], 1'b0, base_q, base_done,
                                ERR_NONE, last_send);
            // first send of a packet initializes its memory entries
            mark_we   = 1'b1;
            ret_we    = 1'b1;
            next_d    = next_q + 1'b1;
            credit_d  = credit_q - 1'b1;
            if (last_send) begin
              state_d = ST_IDLE;
            end
          end
        end else if (can_emit) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_TO_RD: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (ret_rd_q >= cfg_i.retry_limit) begin
            failed_d             = 1'b1;
            emit_word.error_code = ERR_FAILED;
          end else begin
            ret_we    = 1'b1;
            ret_wa    = base_q[PKT_W-1:0];
            ret_wd    = ret_rd_q + 1'b1;
            credit_d  = '0;
            emit_word = mk_word(1'b1, base_q[PKT_W-1:0], 1'b1, base_q, base_done,
                                ERR_NONE, 1'b1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    ov_d = ov_q;
    od_d = od_q;
    if (emit) begin
      ov_d = 1'b1;
      od_d = emit_word;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      base_q   <= '0;
      next_q   <= '0;
      credit_q <= '0;
      slid_q   <= '0;
      failed_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      next_q   <= next_d;
      credit_q <= credit_d;
      slid_q   <= slid_d;
      failed_q <= failed_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aseq_q <= aseq_d;
    od_q   <= od_d;
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (mark_re) begin
      mark_rd_q <= mark_mem[mark_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ret_we) begin
      ret_mem[ret_wa] <= ret_wd;
    end
    if (ret_re) begin
      ret_rd_q <= ret_mem[ret_ra];
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= WIN_W'(MAX_WINDOW))
    else $error("credit above window limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (base_q <= next_q) && (next_q <= SEQ_W'(MAX_PACKETS)))
    else $error("window base passed next sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_word.send_valid) |-> !failed_q)
    else $error("send issued on a failed transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND && emit && emit_word.last) |=> (state_q == ST_IDLE))
    else $error("sequencer kept sending after the last word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SLIDE_CHK) |-> $past(mark_re))
    else $error("slide check without a mark read");

endmodule
`default_nettype wire

### hdl/sliding_window_arq_sender_top.sv
// Top level of the sliding window ARQ sender: config registers, front, back.
// A status word passes the command queue and the output register; a timeout resend
//   adds the retry memory read; start sends pass ST_SEND, then one per cycle while
//   the output is free. One event at a time in the sequencer; an ack reads its mark,
//   ST_SLIDE/ST_SLIDE_CHK per packet slid (one mark memory read port), then sends.
// Reset: clears window state, queue and output valid; memories are not cleared, each
//   entry is initialized when its packet is first sent, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_arq_sender_top import swarq_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_word_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_word_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [WIN_W-1:0]   window_q;
  logic [SEQ_W-1:0]   total_q;
  logic [RETRY_W-1:0] retry_q;
  cfg_t               cfg;
  logic               cmd_valid, cmd_pop;
  cmd_t               cmd;

  // Config writes are always taken; an index beyond the register list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_W'(4);
      total_q  <= SEQ_W'(1);
      retry_q  <= RETRY_W'(4);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WINDOW_SIZE:   window_q <= cfg_data_i[WIN_W-1:0];
        CFG_TOTAL_PACKETS: total_q  <= cfg_data_i[SEQ_W-1:0];
        CFG_RETRY_LIMIT:   retry_q  <= cfg_data_i[RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp window to 1..MAX_WINDOW and total to 1..MAX_PACKETS.
  always_comb begin
    cfg.window = window_q;
    if (window_q == '0) begin
      cfg.window = WIN_W'(1);
    end else if (window_q > WIN_W'(MAX_WINDOW)) begin
      cfg.window = WIN_W'(MAX_WINDOW);
    end
    cfg.total = total_q;
    if (total_q == '0) begin
      cfg.total = SEQ_W'(1);
    end else if (total_q > SEQ_W'(MAX_PACKETS)) begin
      cfg.total = SEQ_W'(MAX_PACKETS);
    end
    cfg.retry_limit = retry_q;
  end

  // Front: take event words and queue them as decoded commands.
  swarq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: run each command against the window state and emit result words.
  swarq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### sim/sliding_window_arq_sender_top_test.sv
// Self-checking testbench for the sliding window ARQ sender top level.
`timescale 1ns / 1ps
module sliding_window_arq_sender_top_test;
  import swarq_pkg::*;

  localparam logic [1:0] KIND_NOP = OP_NOP;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sliding_window_arq_sender_top u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Window bookkeeping mirror: registers as written, window state, per-packet
  // ack marks and retry counts.
  // ---------------------------------------------------------------------------
  logic [5:0]         win_reg = 6'd4;
  logic [10:0]        total_reg = 11'd1;
  logic [2:0]         limit_reg = 3'd4;
  logic [SEQ_W-1:0]   base_q;
  logic [SEQ_W-1:0]   next_q;
  logic [WIN_W-1:0]   credit_q;
  logic               failed_q;
  logic               acked_q [MAX_PACKETS];
  logic [RETRY_W-1:0] tries_q [MAX_PACKETS];

  out_word_t step_words[$];  // words caused by the event just stepped
  out_word_t due_words[$];   // words still owed by the block, oldest first

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int acted_items = 0;
  int mismatches = 0;

  function automatic int eff_total();
    if (total_reg == 0) return 1;
    if (total_reg > MAX_PACKETS) return MAX_PACKETS;
    return total_reg;
  endfunction

  function automatic int eff_window();
    if (win_reg == 0) return 1;
    if (win_reg > MAX_WINDOW) return MAX_WINDOW;
    return win_reg;
  endfunction

  function automatic out_word_t word_of(logic valid, int seq, logic retx, int base,
                                        logic done, logic [1:0] err);
    out_word_t o;
    o.send_valid    = valid;
    o.send_seq      = PKT_W'(seq);
    o.is_retransmit = retx;
    o.window_base   = SEQ_W'(base);
    o.done_res      = done;
    o.error_code    = err;
    o.last          = 1'b1;
    return o;
  endfunction

  function automatic void clear_window();
    base_q   = '0;
    next_q   = '0;
    credit_q = '0;
    failed_q = 1'b0;
    foreach (acked_q[i]) begin
      acked_q[i] = 1'b0;
      tries_q[i] = '0;
    end
  endfunction

  // Spend the credit on fresh sends, never past the (clamped) total.
  function automatic void issue_sends();
    int guard;
    guard = 0;
    while (credit_q > 0 && next_q < eff_total() && guard < MAX_WINDOW) begin
      step_words.push_back(word_of(1'b1, next_q, 1'b0, 0, 1'b0, ERR_NONE));
      next_q++;
      credit_q--;
      guard++;
    end
  endfunction

  // Advance the window by one event; leave its words in step_words.
  // Return 1 unless the block merely ignores the event.
  function automatic bit window_step(in_word_t w);
    logic [1:0] err;
    int         slid;
    bit         acted;
    out_word_t  o;
    err   = ERR_NONE;
    acted = 1'b0;
    step_words.delete();
    case (w.kind)
      KIND_START: begin
        clear_window();
        credit_q = WIN_W'(eff_window());
        issue_sends();
        acted = 1'b1;
      end
      KIND_ACK: begin
        if (!failed_q && base_q < eff_total()) begin
          acted = 1'b1;
          if (w.ack_seq >= next_q) begin
            err = ERR_RANGE;
          end else if (!acked_q[w.ack_seq]) begin
            acked_q[w.ack_seq] = 1'b1;
            // only an ack at the base moves the window
            if (w.ack_seq == base_q) begin
              slid = 0;
              while (base_q < next_q && acked_q[base_q]) begin
                base_q++;
                slid++;
              end
              credit_q = WIN_W'((slid > MAX_WINDOW) ? MAX_WINDOW : slid);
              issue_sends();
            end
          end
        end
      end
      KIND_TIMEOUT: begin
        if (!failed_q && base_q < eff_total() && base_q < next_q) begin
          acted = 1'b1;
          if (tries_q[base_q] >= limit_reg) begin
            failed_q = 1'b1;
          end else begin
            tries_q[base_q]++;
            step_words.push_back(word_of(1'b1, base_q, 1'b1, 0, 1'b0, ERR_NONE));
            credit_q = '0;
          end
        end
      end
      default: ;
    endcase
    if (failed_q) err = ERR_FAILED;
    if (step_words.size() == 0) step_words.push_back(word_of(1'b0, 0, 1'b0, 0, 1'b0, ERR_NONE));
    foreach (step_words[i]) begin
      o = step_words[i];
      o.window_base = base_q;
      o.done_res    = (base_q >= eff_total());
      o.error_code  = err;
      o.last        = (i == step_words.size() - 1);
      step_words[i] = o;
    end
    return acted;
  endfunction

  // ---------------------------------------------------------------------------
  // Event driver: random gaps, then hold the word until it is taken. Valid is
  // left high on return so back-to-back words need no extra edge.
  // ---------------------------------------------------------------------------
  task automatic send_event(in_word_t w, bit typed, out_word_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (window_step(w)) acted_items++;
    if (typed) due_words.push_back(want);
    else foreach (step_words[i]) due_words.push_back(step_words[i]);
  endtask

  // Write all three registers once the block has drained.
  task automatic set_config(logic [5:0] win, logic [10:0] tot, logic [2:0] lim);
    logic [CFG_DATA_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0]  regs [3];
    in_valid_i <= 1'b0;
    vals = '{CFG_DATA_W'(win), tot, CFG_DATA_W'(lim)};
    regs = '{CFG_WINDOW_SIZE, CFG_TOTAL_PACKETS, CFG_RETRY_LIMIT};
    while (due_words.size() != 0) @(posedge clk_i);
    // let the sequencer finish its last status word before touching registers
    repeat (6) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    win_reg   = win;
    total_reg = tot;
    limit_reg = lim;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: acks of packets in flight, some timeouts,
  // plus duplicates, stray acks, no-ops and restarts.
  function automatic in_word_t pick_event();
    in_word_t w;
    int       r;
    int       span;
    w.ack_seq = PKT_W'($urandom);
    r = $urandom_range(99);
    if (failed_q || base_q >= eff_total() || base_q >= next_q) begin
      if (r < 75) w.kind = KIND_START;
      else if (r < 85) w.kind = KIND_NOP;
      else if (r < 93) w.kind = KIND_ACK;
      else w.kind = KIND_TIMEOUT;
      return w;
    end
    span = next_q - base_q;
    if (r < 55) begin
      w.kind = KIND_ACK;
      w.ack_seq = ($urandom_range(2) == 0) ? PKT_W'(base_q)
                                           : PKT_W'(base_q + $urandom_range(span - 1));
    end else if (r < 68) begin
      w.kind = KIND_TIMEOUT;
    end else if (r < 76) begin
      w.kind = KIND_ACK;
      w.ack_seq = PKT_W'($urandom_range(next_q - 1));
    end else if (r < 84) begin
      w.kind = KIND_ACK;
      if (next_q <= MAX_PACKETS - 1) w.ack_seq = PKT_W'($urandom_range(MAX_PACKETS - 1, next_q));
    end else if (r < 92) begin
      w.kind = KIND_NOP;
    end else begin
      w.kind = KIND_START;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan: events, some with their single result word typed in, and
  // register writes between them.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit         is_cfg;
    in_word_t   ev;
    bit         typed;
    out_word_t  want;
    logic [5:0] win;
    logic [10:0] tot;
    logic [2:0] lim;
  } row_t;

  row_t plan[$];

  function automatic void add_event(logic [1:0] kind, int seq);
    row_t r;
    r = '{default: '0};
    r.ev = '{kind: kind, ack_seq: PKT_W'(seq)};
    plan.push_back(r);
  endfunction

  function automatic void add_known(logic [1:0] kind, int seq, out_word_t want);
    row_t r;
    r = '{default: '0};
    r.ev    = '{kind: kind, ack_seq: PKT_W'(seq)};
    r.typed = 1'b1;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic void add_config(logic [5:0] win, logic [10:0] tot, logic [2:0] lim);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.win    = win;
    r.tot    = tot;
    r.lim    = lim;
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_ready
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic string show(out_word_t o);
    return $sformatf("valid=%0d seq=%0d retx=%0d base=%0d done=%0d err=%0d last=%0d",
                     o.send_valid, o.send_seq, o.is_retransmit, o.window_base,
                     o.done_res, o.error_code, o.last);
  endfunction

  // Compare every taken result word with the oldest owed one.
  always @(posedge clk_i) begin : check_words
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_words.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: %s", show(out_data_o));
        mismatches++;
      end else begin
        want = due_words.pop_front();
        if (out_data_o.send_valid !== want.send_valid ||
            out_data_o.send_seq !== want.send_seq ||
            out_data_o.is_retransmit !== want.is_retransmit ||
            out_data_o.window_base !== want.window_base ||
            out_data_o.done_res !== want.done_res ||
            out_data_o.error_code !== want.error_code ||
            out_data_o.last !== want.last) begin
          if (mismatches < 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(out_data_o));
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    in_word_t w;
    int       n;
    int       first;
    int       drain;
    clear_window();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: window 4, one packet, four retries.
    add_known(KIND_ACK, 0, word_of(1'b0, 0, 1'b0, 0, 1'b0, ERR_RANGE));
    add_known(KIND_TIMEOUT, 10'h3FF, word_of(1'b0, 0, 1'b0, 0, 1'b0, ERR_NONE));
    add_known(KIND_NOP, 10'h3FF, word_of(1'b0, 0, 1'b0, 0, 1'b0, ERR_NONE));
    add_known(KIND_START, 0, word_of(1'b1, 0, 1'b0, 0, 1'b0, ERR_NONE));
    add_known(KIND_ACK, 10'h3FF, word_of(1'b0, 0, 1'b0, 0, 1'b0, ERR_RANGE));
    add_known(KIND_TIMEOUT, 0, word_of(1'b1, 0, 1'b1, 0, 1'b0, ERR_NONE));
    add_known(KIND_ACK, 0, word_of(1'b0, 0, 1'b0, 1, 1'b1, ERR_NONE));
    add_known(KIND_ACK, 0, word_of(1'b0, 0, 1'b0, 1, 1'b1, ERR_NONE));
    add_known(KIND_TIMEOUT, 0, word_of(1'b0, 0, 1'b0, 1, 1'b1, ERR_NONE));
    // Oversized registers clamp; zero retries fail on the first timeout.
    add_config(6'h3F, 11'h7FF, 3'd0);
    add_event(KIND_START, 0);
    add_known(KIND_TIMEOUT, 0, word_of(1'b0, 0, 1'b0, 0, 1'b0, ERR_FAILED));
    add_known(KIND_ACK, 0, word_of(1'b0, 0, 1'b0, 0, 1'b0, ERR_FAILED));
    add_known(KIND_TIMEOUT, 0, word_of(1'b0, 0, 1'b0, 0, 1'b0, ERR_FAILED));
    // Zero window and zero total clamp up to one.
    add_config(6'd0, 11'd0, 3'd7);
    add_known(KIND_START, 0, word_of(1'b1, 0, 1'b0, 0, 1'b0, ERR_NONE));
    add_known(KIND_ACK, 0, word_of(1'b0, 0, 1'b0, 1, 1'b1, ERR_NONE));
    // Out-of-order and duplicate acks, slide, resend, then retry exhaustion.
    add_config(6'd5, 11'd12, 3'd1);
    add_event(KIND_START, 0);
    add_event(KIND_ACK, 2);
    add_event(KIND_ACK, 2);
    add_event(KIND_ACK, 1);
    add_event(KIND_ACK, 0);
    add_event(KIND_TIMEOUT, 0);
    add_event(KIND_TIMEOUT, 0);
    add_event(KIND_START, 0);
    // Shrink the total below next_seq in the middle of a transfer.
    add_config(6'd5, 11'd3, 3'd1);
    add_event(KIND_ACK, 0);
    add_event(KIND_ACK, 4);
    add_event(KIND_ACK, 1);
    add_event(KIND_ACK, 2);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_config(plan[i].win, plan[i].tot, plan[i].lim);
      else send_event(plan[i].ev, plan[i].typed, plan[i].want);
    end

    // Random phases, each with fresh registers and its own idling pattern.
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3))
        0: win_reg = 6'd1;
        1: win_reg = 6'd32;
        2: win_reg = 6'($urandom_range(1, 8));
        default: win_reg = 6'($urandom_range(63));
      endcase
      case ($urandom_range(5))
        0: total_reg = 11'd1;
        1: total_reg = 11'd1024;
        2: total_reg = 11'($urandom_range(2047));
        default: total_reg = 11'($urandom_range(2, 40));
      endcase
      set_config(win_reg, total_reg, 3'($urandom_range(7)));
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase
      first = acted_items;
      n = 0;
      while (acted_items - first < 22) begin
        // hold the receiver off while events keep coming, to back up the block
        if (phase == 0 && n == 4) hold_asks++;
        // stop offering until every owed word has come out
        if (phase == 1 && n == 14) begin
          in_valid_i <= 1'b0;
          while (due_words.size() != 0) @(posedge clk_i);
        end
        w = pick_event();
        send_event(w, 1'b0, '0);
        n++;
      end
    end

    in_valid_i <= 1'b0;
    drain = 0;
    while (due_words.size() != 0 && drain < 50000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (due_words.size() != 0) $display("%0d expected words never came", due_words.size());
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
